// ===== src/sdsq_pkg.sv =====
// shared types and constants of the sd spi command sequencer
// no dependencies; imported by sdsq_step, sdsq_out_buf and the top level
`timescale 1ns / 1ps
`default_nettype none

package sdsq_pkg;

  // request codes carried in tuser of the input stream
  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdRxByte = 2'd1;
  localparam logic [1:0] CmdIdleClocks = 2'd2;

  // sequencer phases
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhDesel = 3'd1;
  localparam logic [2:0] PhSel = 3'd2;
  localparam logic [2:0] PhReady = 3'd3;
  localparam logic [2:0] PhFrame = 3'd4;
  localparam logic [2:0] PhR1 = 3'd5;
  localparam logic [2:0] PhLong = 3'd6;
  localparam logic [2:0] PhClocks = 3'd7;

  // result kinds
  localparam logic KindXfer = 1'b0;
  localparam logic KindDone = 1'b1;

  // configuration register indexes
  localparam logic CfgReadyWaitLimit = 1'b0;
  localparam logic CfgR1PollLimit = 1'b1;

  localparam int unsigned LongRespBytesDefault = 4;
  localparam logic [15:0] ReadyWaitLimitReset = 16'd250;
  localparam logic [7:0] R1PollLimitReset = 8'd100;

  localparam logic [7:0] FrameStartBits = 8'h40;
  localparam logic [7:0] DummyByte = 8'hFF;
  localparam logic [7:0] StatusNone = 8'hFF;

  typedef struct packed {
    logic [2:0] phase;
    logic [15:0] poll_count;
    logic [2:0] byte_index;
    logic [5:0] held_index;
    logic [31:0] held_argument;
    logic [7:0] held_crc;
    logic held_long_flag;
    logic [7:0] held_status;
    logic [31:0] response_shift;
    logic [7:0] idle_remaining;
  } sdsq_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cmd_index;
    logic [31:0] argument;
    logic [7:0] frame_crc;
    logic want_long_response;
    logic keep_selected;
    logic [7:0] clock_count;
    logic [7:0] rx_byte;
  } sdsq_item_t;

  typedef struct packed {
    logic kind;
    logic [7:0] tx_byte;
    logic select_asserted;
    logic pause_first;
    logic [7:0] status_r1;
    logic [31:0] long_response;
    logic timed_out;
  } sdsq_result_t;

  localparam sdsq_state_t StateReset = '{
    phase: PhIdle,
    poll_count: 16'd0,
    byte_index: 3'd0,
    held_index: 6'd0,
    held_argument: 32'd0,
    held_crc: 8'd0,
    held_long_flag: 1'b0,
    held_status: StatusNone,
    response_shift: 32'd0,
    idle_remaining: 8'd0
  };

endpackage

`default_nettype wire

// ===== src/sdsq_step.sv =====
// next-state and result logic of the sequencer for one accepted item
// depends on sdsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdsq_step import sdsq_pkg::*; #(
  parameter int unsigned LONG_RESPONSE_BYTES = LongRespBytesDefault
) (
  input  sdsq_state_t  state_i,
  input  sdsq_item_t   item_i,
  input  logic [15:0]  ready_wait_limit_i,
  input  logic [7:0]   r1_poll_limit_i,
  output sdsq_state_t  state_o,
  output logic         res_valid_o,
  output sdsq_result_t res_o
);

  localparam logic [3:0] LastLongIdx = 4'(LONG_RESPONSE_BYTES);

  logic [15:0] poll_inc;
  logic [2:0] byte_inc;
  logic [31:0] shift_in;
  logic [7:0] frame_sel;

  assign poll_inc = state_i.poll_count + 16'd1;
  assign byte_inc = state_i.byte_index + 3'd1;
  assign shift_in = {state_i.response_shift[23:0], item_i.rx_byte};

  always_comb begin
    case (byte_inc)
      3'd1: frame_sel = state_i.held_argument[31:24];
      3'd2: frame_sel = state_i.held_argument[23:16];
      3'd3: frame_sel = state_i.held_argument[15:8];
      3'd4: frame_sel = state_i.held_argument[7:0];
      default: frame_sel = state_i.held_crc;
    endcase
  end

  always_comb begin
    state_o = state_i;
    res_valid_o = 1'b0;
    res_o = '0;
    case (item_i.command)
      CmdStart: begin
        state_o.held_index = item_i.cmd_index;
        state_o.held_argument = item_i.argument;
        state_o.held_crc = item_i.frame_crc;
        state_o.held_long_flag = item_i.want_long_response;
        state_o.held_status = StatusNone;
        state_o.response_shift = 32'd0;
        state_o.byte_index = 3'd0;
        state_o.poll_count = 16'd0;
        res_valid_o = 1'b1;
        if (!item_i.keep_selected) begin
          state_o.phase = PhDesel;
          res_o.tx_byte = DummyByte;
        end else if (ready_wait_limit_i == 16'd0) begin
          state_o.phase = PhIdle;
          res_o.kind = KindDone;
          res_o.status_r1 = StatusNone;
          res_o.timed_out = 1'b1;
        end else begin
          state_o.phase = PhReady;
          res_o.tx_byte = DummyByte;
          res_o.select_asserted = 1'b1;
        end
      end
      CmdIdleClocks: begin
        res_valid_o = 1'b1;
        if (item_i.clock_count == 8'd0) begin
          state_o.phase = PhIdle;
          res_o.kind = KindDone;
          res_o.status_r1 = StatusNone;
        end else begin
          state_o.idle_remaining = item_i.clock_count - 8'd1;
          state_o.phase = PhClocks;
          res_o.tx_byte = DummyByte;
        end
      end
      CmdRxByte: begin
        res_valid_o = (state_i.phase != PhIdle);
        res_o.tx_byte = DummyByte;
        res_o.select_asserted = 1'b1;
        case (state_i.phase)
          PhDesel: begin
            state_o.phase = PhSel;
          end
          PhSel: begin
            state_o.poll_count = 16'd0;
            if (ready_wait_limit_i == 16'd0) begin
              state_o.phase = PhIdle;
              res_o = '0;
              res_o.kind = KindDone;
              res_o.status_r1 = StatusNone;
              res_o.timed_out = 1'b1;
            end else begin
              state_o.phase = PhReady;
            end
          end
          PhReady: begin
            if (item_i.rx_byte == DummyByte) begin
              state_o.phase = PhFrame;
              state_o.byte_index = 3'd0;
              res_o.tx_byte = FrameStartBits | {2'b00, state_i.held_index};
            end else begin
              state_o.poll_count = poll_inc;
              if (poll_inc >= ready_wait_limit_i) begin
                state_o.phase = PhIdle;
                res_o = '0;
                res_o.kind = KindDone;
                res_o.status_r1 = StatusNone;
                res_o.timed_out = 1'b1;
              end else begin
                res_o.pause_first = 1'b1;
              end
            end
          end
          PhFrame: begin
            state_o.byte_index = byte_inc;
            if (byte_inc < 3'd6) begin
              res_o.tx_byte = frame_sel;
            end else begin
              // frame done: start the status poll, or skip it if the poll limit is zero
              state_o.poll_count = 16'd0;
              state_o.held_status = StatusNone;
              if (r1_poll_limit_i != 8'd0) begin
                state_o.phase = PhR1;
              end else if (state_i.held_long_flag) begin
                state_o.phase = PhLong;
                state_o.byte_index = 3'd0;
                state_o.response_shift = 32'd0;
              end else begin
                state_o.phase = PhIdle;
                res_o = '0;
                res_o.kind = KindDone;
                res_o.status_r1 = StatusNone;
              end
            end
          end
          PhR1: begin
            state_o.held_status = item_i.rx_byte;
            state_o.poll_count = poll_inc;
            if (!item_i.rx_byte[7] || (poll_inc >= {8'd0, r1_poll_limit_i})) begin
              if (state_i.held_long_flag) begin
                state_o.phase = PhLong;
                state_o.byte_index = 3'd0;
                state_o.response_shift = 32'd0;
              end else begin
                state_o.phase = PhIdle;
                res_o = '0;
                res_o.kind = KindDone;
                res_o.status_r1 = item_i.rx_byte;
              end
            end
          end
          PhLong: begin
            state_o.response_shift = shift_in;
            if ({1'b0, state_i.byte_index} + 4'd1 >= LastLongIdx) begin
              state_o.phase = PhIdle;
              res_o = '0;
              res_o.kind = KindDone;
              res_o.status_r1 = state_i.held_status;
              res_o.long_response = shift_in;
            end else begin
              state_o.byte_index = byte_inc;
            end
          end
          PhClocks: begin
            res_o.select_asserted = 1'b0;
            if (state_i.idle_remaining == 8'd0) begin
              state_o.phase = PhIdle;
              res_o = '0;
              res_o.kind = KindDone;
              res_o.status_r1 = StatusNone;
            end else begin
              state_o.idle_remaining = state_i.idle_remaining - 8'd1;
            end
          end
          default: begin
            res_o = '0;
          end
        endcase
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sdsq_out_buf.sv =====
// two-entry result buffer between the sequencer and the output stream
// depends on sdsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdsq_out_buf import sdsq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  sdsq_result_t push_data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output sdsq_result_t data_o
);

  sdsq_result_t slot_q [2];
  logic wr_ptr_q, wr_ptr_d;
  logic rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic do_pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o = (count_q == 2'd2);
  assign do_pop = pop_i && valid_o;
  assign data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/sd_spi_command_sequencer_top.sv =====
// top level of the sd card spi-mode command sequencer
// depends on sdsq_pkg, sdsq_step and sdsq_out_buf
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata item fields, tuser request code
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata result fields, tuser kind
// cfg       in   cfg_we_i                         cfg_index_i, cfg_data_i
//
// one item per cycle unless the result buffer is full: the sequencer state is a register,
// the step logic computes next state and result in the same cycle as the transfer
// results go into a two-entry buffer, so items keep flowing while one waits
// s_axis_tready_o drops only when both buffer entries are occupied
// reset puts the sequencer idle and the limits at 250 and 100
// an item producing no result (received byte while idle, code 3) is dropped
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_command_sequencer_top import sdsq_pkg::*; #(
  parameter int unsigned LONG_RESPONSE_BYTES = LongRespBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd_index[5:0], argument[37:6], frame_crc[45:38], want_long_response[46],
  // keep_selected[47], clock_count[55:48], rx_byte[63:56]
  input  logic [63:0] s_axis_tdata_i,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tx_byte[7:0], select_asserted[8], pause_first[9], status_r1[17:10],
  // long_response[49:18], timed_out[50], zero fill [55:51]
  output logic [55:0] m_axis_tdata_o,
  // kind[0]
  output logic        m_axis_tuser_o
);

  sdsq_state_t state_q, state_d;
  sdsq_item_t item;
  sdsq_result_t step_res, out_res;
  logic step_res_valid;
  logic [15:0] ready_wait_limit_q;
  logic [7:0] r1_poll_limit_q;
  logic accept;
  logic push;
  logic buf_full;

  // unpack the input transfer
  assign item.command = s_axis_tuser_i;
  assign item.cmd_index = s_axis_tdata_i[5:0];
  assign item.argument = s_axis_tdata_i[37:6];
  assign item.frame_crc = s_axis_tdata_i[45:38];
  assign item.want_long_response = s_axis_tdata_i[46];
  assign item.keep_selected = s_axis_tdata_i[47];
  assign item.clock_count = s_axis_tdata_i[55:48];
  assign item.rx_byte = s_axis_tdata_i[63:56];

  assign s_axis_tready_o = !buf_full;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign push = accept && step_res_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_wait_limit_q <= ReadyWaitLimitReset;
      r1_poll_limit_q <= R1PollLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgReadyWaitLimit: ready_wait_limit_q <= cfg_data_i;
        CfgR1PollLimit: r1_poll_limit_q <= cfg_data_i[7:0];
        default: ready_wait_limit_q <= ready_wait_limit_q;
      endcase
    end
  end

  sdsq_step #(
    .LONG_RESPONSE_BYTES(LONG_RESPONSE_BYTES)
  ) u_step (
    .state_i            (state_q),
    .item_i             (item),
    .ready_wait_limit_i (ready_wait_limit_q),
    .r1_poll_limit_i    (r1_poll_limit_q),
    .state_o            (state_d),
    .res_valid_o        (step_res_valid),
    .res_o              (step_res)
  );

  // sequencer state advances only on an accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  sdsq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (step_res),
    .full_o      (buf_full),
    .valid_o     (m_axis_tvalid_o),
    .pop_i       (m_axis_tready_i),
    .data_o      (out_res)
  );

  // pack the result transfer
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {5'd0, out_res.timed_out, out_res.long_response,
                           out_res.status_r1, out_res.pause_first,
                           out_res.select_asserted, out_res.tx_byte};

`ifndef ASSERT_OFF
  // input stalls only while results are waiting downstream
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty result buffer");

  // a finished result always leaves the sequencer idle
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && (step_res.kind == KindDone) |=> state_q.phase == PhIdle)
    else $error("finished result but sequencer not idle");

  // a pause is only requested between failed ready polls
  a_pause_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && step_res.pause_first |=> state_q.phase == PhReady)
    else $error("pause requested outside ready polling");

  // select is released only for the deselect dummy and idle clocks
  a_deselect_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && (step_res.kind == KindXfer) && !step_res.select_asserted
    |=> state_q.phase == PhDesel || state_q.phase == PhClocks)
    else $error("select released in a command phase");
`endif

endmodule

`default_nettype wire
